[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/mfa_pkg.sv]
package mfa_pkg;

  localparam logic [2:0] OP_CMP  = 3'd0;
  localparam logic [2:0] OP_TST  = 3'd1;
  localparam logic [2:0] OP_BTST = 3'd2;
  localparam logic [2:0] OP_LSR  = 3'd3;
  localparam logic [2:0] OP_LSL  = 3'd4;
  localparam logic [2:0] OP_SWAP = 3'd5;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_WORD = 2'd1;

  localparam int FLAG_C = 0;
  localparam int FLAG_V = 1;
  localparam int FLAG_Z = 2;
  localparam int FLAG_N = 3;
  localparam int FLAG_X = 4;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [1:0]  op_size;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [7:0]  bit_or_count;
    logic [15:0] status_in;
  } mfa_req_t;

  typedef struct packed {
    logic [31:0] result;
    logic [15:0] status_out;
  } mfa_res_t;

  function automatic logic [31:0] size_mask(logic [1:0] sz);
    logic [31:0] m;
    case (sz)
      SZ_BYTE: m = 32'h0000_00FF;
      SZ_WORD: m = 32'h0000_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic sign_bit(logic [31:0] v, logic [1:0] sz);
    logic s;
    case (sz)
      SZ_BYTE: s = v[7];
      SZ_WORD: s = v[15];
      default: s = v[31];
    endcase
    return s;
  endfunction

endpackage

[rtl/core/m68k_flag_alu_subset.sv]
// Condition-code ALU subset: compare, test, bit test, logical shifts and half-word
// swap. An item is taken at every clock edge where start is high; busy is held low,
// so a new beat may be issued in every cycle. Each item is registered on entry and
// its result is registered on exit: start passes through valid_r and out_valid_r,
// the request through req_r and res_r, to out_valid and out_data; the sustained
// rate of one item per cycle is set by the single pass through the subtractor and
// barrel shifter. out_valid is high for exactly one cycle per result and the
// receiver cannot stall the block, so results must be captured when strobed.
`include "assert_macros.svh"

module m68k_flag_alu_subset
  import mfa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  mfa_req_t in_data,
  output logic     out_valid,
  output mfa_res_t out_data
);

  logic     valid_r;
  mfa_req_t req_r;
  logic     out_valid_r;
  mfa_res_t res_r;
  mfa_res_t res_nxt;

  logic [31:0] mask;
  logic [31:0] d_val;
  logic [31:0] s_val;
  logic [31:0] diff;
  logic [31:0] sh_val;
  logic [31:0] lsr_val;
  logic [31:0] lsr_prev;
  logic [32:0] lsl_wide;
  logic        lsr_last;
  logic        lsl_last;
  logic [4:0]  bit_sel;
  logic [7:0]  cnt;
  logic [15:0] sr;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= start && !busy;
      out_valid_r <= valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r <= in_data;
    end
    res_r <= res_nxt;
  end

  assign cnt      = req_r.bit_or_count;
  assign mask     = size_mask(req_r.op_size);
  assign d_val    = req_r.operand_a & mask;
  assign s_val    = req_r.operand_b & mask;
  assign diff     = (d_val - s_val) & mask;
  assign sh_val   = d_val;
  assign lsr_val  = sh_val >> cnt;
  assign lsr_prev = sh_val >> (cnt - 8'd1);
  assign lsr_last = lsr_prev[0];
  assign lsl_wide = {1'b0, sh_val} << cnt;
  assign bit_sel  = (req_r.op_size == SZ_BYTE) ? {2'b00, cnt[2:0]} : cnt[4:0];

  always_comb begin
    case (req_r.op_size)
      SZ_BYTE: lsl_last = lsl_wide[8];
      SZ_WORD: lsl_last = lsl_wide[16];
      default: lsl_last = lsl_wide[32];
    endcase
  end

  always_comb begin
    sr      = req_r.status_in;
    res_nxt = '0;
    unique case (req_r.req_type) inside
      OP_CMP: begin
        sr[3:0]     = 4'b0000;
        sr[FLAG_Z]  = (diff == 32'd0);
        sr[FLAG_N]  = sign_bit(diff, req_r.op_size);
        sr[FLAG_C]  = (d_val < s_val);
        sr[FLAG_V]  = (sign_bit(d_val, req_r.op_size) != sign_bit(s_val, req_r.op_size))
                   && (sign_bit(d_val, req_r.op_size) != sign_bit(diff, req_r.op_size));
      end
      OP_TST: begin
        sr[3:0]    = 4'b0000;
        sr[FLAG_Z] = (d_val == 32'd0);
        sr[FLAG_N] = sign_bit(req_r.operand_a, req_r.op_size);
      end
      OP_BTST: begin
        sr[FLAG_Z] = !req_r.operand_a[bit_sel];
      end
      OP_LSR, OP_LSL: begin
        if (cnt == 8'd0) begin
          res_nxt.result = req_r.operand_a;
          sr[FLAG_C]     = 1'b0;
          sr[FLAG_V]     = 1'b0;
        end else if (req_r.req_type == OP_LSR) begin
          res_nxt.result = (req_r.operand_a & ~mask) | lsr_val;
          sr[4:0]        = 5'b00000;
          sr[FLAG_Z]     = (lsr_val == 32'd0);
          sr[FLAG_N]     = sign_bit(lsr_val, req_r.op_size);
          sr[FLAG_C]     = lsr_last;
          sr[FLAG_X]     = lsr_last;
        end else begin
          res_nxt.result = (req_r.operand_a & ~mask) | (lsl_wide[31:0] & mask);
          sr[4:0]        = 5'b00000;
          sr[FLAG_Z]     = ((lsl_wide[31:0] & mask) == 32'd0);
          sr[FLAG_N]     = sign_bit(lsl_wide[31:0], req_r.op_size);
          sr[FLAG_C]     = lsl_last;
          sr[FLAG_X]     = lsl_last;
        end
      end
      OP_SWAP: begin
        res_nxt.result = {req_r.operand_a[15:0], req_r.operand_a[31:16]};
        sr[3:0]        = 4'b0000;
        sr[FLAG_Z]     = (req_r.operand_a == 32'd0);
        sr[FLAG_N]     = req_r.operand_a[15];
      end
      default: begin
        res_nxt.result = '0;
      end
    endcase
    res_nxt.status_out = sr;
  end

  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  `ASSERT_NEXT(a_issue_to_stage, start && !busy, valid_r)
  `ASSERT_NEXT(a_stage_to_out, valid_r, out_valid)
  `ASSERT_NEXT(a_upper_status_kept, valid_r,
               out_data.status_out[15:5] == $past(req_r.status_in[15:5]))
  `ASSERT_NEXT(a_flag_only_zero, valid_r && (req_r.req_type == OP_CMP ||
               req_r.req_type == OP_TST || req_r.req_type == OP_BTST),
               out_data.result == 32'd0)

endmodule

[dv/mfa_flag_checker.sv]
`timescale 1ns / 1ps

module mfa_flag_checker
  import mfa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  mfa_req_t in_data,
  input  logic     out_valid,
  input  mfa_res_t out_data,
  output int       fail_count,
  output int       outstanding,
  output int       beats_in,
  output int       beats_out
);

  mfa_res_t ccr_due[$];
  int       fails = 0;
  int       n_in = 0;
  int       n_out = 0;

  function automatic mfa_res_t predict_ccr(mfa_req_t q);
    mfa_res_t    o;
    logic [31:0] mask;
    logic [31:0] d;
    logic [31:0] s;
    logic [31:0] r;
    logic [31:0] v;
    logic [31:0] res;
    logic [15:0] sr;
    logic        last;
    int          width;
    int          cnt;
    int          bitn;
    case (q.op_size)
      SZ_BYTE: begin
        mask  = 32'h0000_00FF;
        width = 8;
      end
      SZ_WORD: begin
        mask  = 32'h0000_FFFF;
        width = 16;
      end
      default: begin
        mask  = 32'hFFFF_FFFF;
        width = 32;
      end
    endcase
    cnt  = int'(q.bit_or_count);
    sr   = q.status_in;
    res  = '0;
    case (q.req_type) inside
      OP_CMP: begin
        d = q.operand_a & mask;
        s = q.operand_b & mask;
        r = (d - s) & mask;
        sr[3:0]     = '0;
        sr[FLAG_Z]  = (r == 0);
        sr[FLAG_N]  = r[width-1];
        sr[FLAG_C]  = (d < s);
        sr[FLAG_V]  = (d[width-1] != s[width-1]) && (d[width-1] != r[width-1]);
      end
      OP_TST: begin
        sr[3:0]    = '0;
        sr[FLAG_Z] = ((q.operand_a & mask) == 0);
        sr[FLAG_N] = q.operand_a[width-1];
      end
      OP_BTST: begin
        bitn       = (q.op_size == SZ_BYTE) ? (cnt & 7) : (cnt & 31);
        sr[FLAG_Z] = ~q.operand_a[bitn];
      end
      OP_LSR, OP_LSL: begin
        if (cnt == 0) begin
          res     = q.operand_a;
          sr[1:0] = '0;
        end else begin
          v    = q.operand_a & mask;
          r    = '0;
          last = 1'b0;
          if (q.req_type == OP_LSR) begin
            if (cnt <= width) last = v[cnt-1];
            if (cnt < width) r = v >> cnt;
          end else begin
            if (cnt <= width) last = v[width-cnt];
            if (cnt < width) r = (v << cnt) & mask;
          end
          res        = (q.operand_a & ~mask) | r;
          sr[4:0]    = '0;
          sr[FLAG_Z] = (r == 0);
          sr[FLAG_N] = r[width-1];
          sr[FLAG_C] = last;
          sr[FLAG_X] = last;
        end
      end
      OP_SWAP: begin
        res        = {q.operand_a[15:0], q.operand_a[31:16]};
        sr[3:0]    = '0;
        sr[FLAG_Z] = (res == 0);
        sr[FLAG_N] = res[31];
      end
      default: begin
      end
    endcase
    o.result     = res;
    o.status_out = sr;
    return o;
  endfunction

  always @(posedge clk) begin : watch
    mfa_res_t want;
    if (rst_n) begin
      if (start && !busy) begin
        ccr_due.push_back(predict_ccr(in_data));
        n_in++;
      end
      if (out_valid) begin
        n_out++;
        if (ccr_due.size() == 0) begin
          $display("%0t: unexpected result beat result=%h status=%h", $time,
                   out_data.result, out_data.status_out);
          fails++;
        end else begin
          want = ccr_due.pop_front();
          if (out_data.result !== want.result) begin
            $display("%0t: result expected %h got %h", $time, want.result,
                     out_data.result);
            fails++;
          end
          if (out_data.status_out !== want.status_out) begin
            $display("%0t: status expected %h got %h", $time, want.status_out,
                     out_data.status_out);
            fails++;
          end
        end
      end
    end
    fail_count  <= fails;
    outstanding <= ccr_due.size();
    beats_in    <= n_in;
    beats_out   <= n_out;
  end

endmodule

[dv/m68k_flag_alu_subset_tb.sv]
`timescale 1ns / 1ps

module m68k_flag_alu_subset_tb;
  import mfa_pkg::*;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam logic [1:0] SZ_LONG   = 2'd2;
  localparam logic [1:0] SZ_ALIAS  = 2'd3;
  localparam int         PHASE_LEN = 260;
  localparam int         STALL_LIMIT = 5000;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  mfa_req_t in_data;
  logic     out_valid;
  mfa_res_t out_data;

  int fail_count;
  int outstanding;
  int beats_in;
  int beats_out;
  int idle_pct;
  int quiet_cycles;

  m68k_flag_alu_subset DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  mfa_flag_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .beats_in    (beats_in),
    .beats_out   (beats_out)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic mfa_req_t mk(logic [2:0] op, logic [1:0] sz, logic [31:0] a,
                                  logic [31:0] b, logic [7:0] c, logic [15:0] sr);
    mfa_req_t q;
    q.req_type     = op;
    q.op_size      = sz;
    q.operand_a    = a;
    q.operand_b    = b;
    q.bit_or_count = c;
    q.status_in    = sr;
    return q;
  endfunction

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    case ($urandom_range(9))
      0: w = '0;
      1: w = '1;
      2: w = 32'h1 << $urandom_range(31);
      3: w = $urandom_range(255);
      4: w = $urandom_range(16'hFFFF);
      5: w = ~(32'h1 << $urandom_range(31));
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic mfa_req_t rand_req();
    mfa_req_t q;
    q.req_type  = ($urandom_range(99) < 95) ? 3'($urandom_range(OP_SWAP))
                                            : 3'($urandom_range(OP_SPARE7, OP_SPARE6));
    q.op_size   = ($urandom_range(19) == 0) ? SZ_ALIAS : 2'($urandom_range(SZ_LONG));
    q.operand_a = rand_word();
    case ($urandom_range(3))
      0: q.operand_b = q.operand_a;
      1: q.operand_b = q.operand_a + $urandom_range(2) - 1;
      default: q.operand_b = rand_word();
    endcase
    q.bit_or_count = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                              : 8'($urandom_range(33));
    q.status_in = 16'($urandom);
    return q;
  endfunction

  task automatic issue(input mfa_req_t q);
    @(negedge clk);
    start   <= 1'b1;
    in_data <= q;
    do @(posedge clk); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start   <= 1'b0;
      in_data <= rand_req();
      while ($urandom_range(99) < idle_pct) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    wait (outstanding == 0);
  endtask

  initial begin : watchdog
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    rst_n    = 1'b0;
    start    = 1'b0;
    in_data  = '0;
    idle_pct = 23;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    issue(mk(OP_CMP,  SZ_BYTE,  32'h0000_0055, 32'h0000_0055, 8'h00, 16'hFFFF));
    issue(mk(OP_CMP,  SZ_BYTE,  32'hFFFF_FF80, 32'h0000_0001, 8'h00, 16'h0000));
    issue(mk(OP_CMP,  SZ_WORD,  32'h0000_0001, 32'h0000_0002, 8'h00, 16'h0010));
    issue(mk(OP_CMP,  SZ_LONG,  32'h7FFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'h0000));
    issue(mk(OP_TST,  SZ_BYTE,  32'hFFFF_FF00, 32'h0, 8'h00, 16'hFFFF));
    issue(mk(OP_TST,  SZ_WORD,  32'h0000_8000, 32'h0, 8'h00, 16'h0000));
    issue(mk(OP_BTST, SZ_BYTE,  32'h0000_0080, 32'h0, 8'h0F, 16'h0000));
    issue(mk(OP_BTST, SZ_LONG,  32'h0000_0008, 32'h0, 8'h23, 16'hFFFF));
    issue(mk(OP_BTST, SZ_WORD,  32'h8000_0000, 32'h0, 8'hFF, 16'h0004));
    issue(mk(OP_LSR,  SZ_LONG,  32'hDEAD_BEEF, 32'h0, 8'h00, 16'hFFFF));
    issue(mk(OP_LSR,  SZ_BYTE,  32'h1234_5681, 32'h0, 8'h01, 16'h0000));
    issue(mk(OP_LSR,  SZ_WORD,  32'hAAAA_8000, 32'h0, 8'h10, 16'h0000));
    issue(mk(OP_LSR,  SZ_BYTE,  32'hFFFF_FFFF, 32'h0, 8'h09, 16'hFFFF));
    issue(mk(OP_LSR,  SZ_LONG,  32'hFFFF_FFFF, 32'h0, 8'hFF, 16'h0000));
    issue(mk(OP_LSL,  SZ_WORD,  32'h0000_8001, 32'h0, 8'h00, 16'h0003));
    issue(mk(OP_LSL,  SZ_BYTE,  32'hFFFF_FF81, 32'h0, 8'h08, 16'h0000));
    issue(mk(OP_LSL,  SZ_LONG,  32'h4000_0001, 32'h0, 8'h01, 16'h0000));
    issue(mk(OP_LSL,  SZ_WORD,  32'hFFFF_FFFF, 32'h0, 8'h20, 16'hFFFF));
    issue(mk(OP_SWAP, SZ_BYTE,  32'h0000_0000, 32'h0, 8'h00, 16'hFFFF));
    issue(mk(OP_SWAP, SZ_LONG,  32'h1234_8765, 32'h0, 8'h00, 16'h0000));
    issue(mk(OP_SPARE6, SZ_LONG, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF));
    issue(mk(OP_SPARE7, SZ_BYTE, 32'h1, 32'h1, 8'h1, 16'h1234));
    issue(mk(OP_CMP,  SZ_ALIAS, 32'h8000_0000, 32'h0000_0001, 8'h00, 16'h0000));
    issue(mk(OP_LSR,  SZ_ALIAS, 32'h8000_0001, 32'h0, 8'h1F, 16'h0000));
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 23 : (ph == 1) ? 74 : 0;
      for (int n = 0; n < PHASE_LEN; n++) issue(rand_req());
      // Hold the sender off until every outstanding beat has been checked.
      drain();
    end

    repeat (8) @(posedge clk);
    $display("Run covered %0d request beats and %0d result beats over directed cases",
             beats_in, beats_out);
    $display("and three random phases with sender idling of 23, 74 and 0 per cent.");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
